FILE: rtl/core/rhss_pkg.sv
// ----------------------------------------------------------------------------
// Rolling hash substring search - shared definitions
// Payload types, hash constants, opcodes and the controller/datapath link.
// ----------------------------------------------------------------------------
package rhss_pkg;

  // Default sizing of the block
  localparam int unsigned MAX_PATTERN_DEF   = 64;
  localparam int unsigned POSITION_BITS_DEF = 32;

  // Hash arithmetic: base 256, prime modulus just below 2^30
  localparam int unsigned HASH_W   = 30;
  localparam logic [HASH_W-1:0] HASH_MOD = 30'd1000000007;
  localparam logic [HASH_W-1:0] BASE_POW1     = 30'd256;
  localparam logic [HASH_W-1:0] NEG_BASE_POW1 = HASH_MOD - BASE_POW1;

  // Reduction of a value below 512 * HASH_MOD.
  // Quotient estimate: ((x >> XL_W) * BARRETT_R) >> BARRETT_SHIFT, short by at most one.
  localparam int unsigned PROD_W        = 39;
  localparam int unsigned XL_W          = 29;
  localparam int unsigned XH_W          = PROD_W - XL_W;
  localparam int unsigned BARRETT_SHIFT = 16;
  localparam logic [BARRETT_SHIFT-1:0] BARRETT_R = 16'd35184;
  localparam int unsigned QPROD_W       = XH_W + BARRETT_SHIFT;
  localparam int unsigned QUO_W         = QPROD_W - BARRETT_SHIFT;
  localparam int unsigned REM_W         = HASH_W + 1;

  // Input opcodes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [5:0] pattern_index;
  } rhss_in_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_start;
  } rhss_out_t;

  // Which value the shared reducer is working on
  typedef enum logic [1:0] {
    JOB_TEXT,
    JOB_PHASH,
    JOB_P256
  } rhss_job_t;

  typedef struct packed {
    logic      accept;
    logic      pat_wr;
    logic      pat_init;
    logic      restart;
    rhss_job_t job;
    logic      mul_en;
    logic      quo_en;
    logic      sub_en;
    logic      fix_en;
    logic      ver_en;
    logic      out_load;
  } rhss_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic idx_zero;
    logic hit;
    logic ver_done;
    logic slot_free;
  } rhss_status_t;

endpackage

FILE: rtl/core/rhss_ctrl.sv
// ----------------------------------------------------------------------------
// Rolling hash substring search - controller
// Sequences accept, modular reduction, verification and result hand-off.
// ----------------------------------------------------------------------------
module rhss_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            opcode,
  input  rhss_pkg::rhss_status_t status,
  output rhss_pkg::rhss_cmd_t    cmd
);
  import rhss_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_QUO  = 7'b0000100,
    ST_SUB  = 7'b0001000,
    ST_FIX  = 7'b0010000,
    ST_VER  = 7'b0100000,
    ST_RES  = 7'b1000000
  } state_t;

  state_t    state, state_next;
  rhss_job_t job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job   <= JOB_TEXT;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.job    = job;
    state_next = state;
    job_next   = job;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (opcode)
            OP_LOAD: begin
              if (status.idx_ok) begin
                cmd.pat_wr = 1'b1;
                if (status.idx_zero) begin
                  cmd.pat_init = 1'b1;
                end else begin
                  job_next   = JOB_PHASH;
                  state_next = ST_MUL;
                end
              end
            end
            OP_TEXT: begin
              job_next   = JOB_TEXT;
              state_next = ST_MUL;
            end
            OP_RESTART: begin
              cmd.restart = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_QUO;
      end
      ST_QUO: begin
        cmd.quo_en = 1'b1;
        state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub_en = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix_en = 1'b1;
        case (job)
          JOB_PHASH: begin
            job_next   = JOB_P256;
            state_next = ST_MUL;
          end
          JOB_TEXT: begin
            if (status.hit) begin
              state_next = ST_VER;
            end else if (status.slot_free) begin
              cmd.out_load = 1'b1;
              state_next   = ST_IDLE;
            end else begin
              state_next = ST_RES;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_VER: begin
        cmd.ver_en = 1'b1;
        if (status.ver_done) state_next = ST_RES;
      end
      ST_RES: begin
        if (status.slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/rhss_dpath.sv
// ----------------------------------------------------------------------------
// Rolling hash substring search - datapath
// Pattern and window stores, hash registers, shared reducer, output register.
// ----------------------------------------------------------------------------
module rhss_dpath #(
  parameter int unsigned MAX_PATTERN   = rhss_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = rhss_pkg::POSITION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rhss_pkg::rhss_in_t     in_item,
  input  logic                   cfg_valid,
  input  logic [6:0]             cfg_data,
  input  rhss_pkg::rhss_cmd_t    cmd,
  output rhss_pkg::rhss_status_t status,
  input  logic                   out_ready,
  output logic                   out_valid,
  output rhss_pkg::rhss_out_t    out_item
);
  import rhss_pkg::*;

  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned LW = (CW > 7) ? CW : 7;
  localparam int unsigned PB = POSITION_BITS;
  localparam logic [CW-1:0] LEN_MAX   = CW'(MAX_PATTERN);
  localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_PATTERN - 1);
  localparam logic [PB-1:0] COUNT_MAX = '1;

  // Stores
  logic [7:0] win_mem [MAX_PATTERN];
  logic [7:0] pat_mem [MAX_PATTERN];
  logic [7:0] win_rdata, pat_rdata;

  // Control and hash state
  logic [CW-1:0]     eff_len, len_next, fill, ver_left;
  logic [AW-1:0]     wp, ver_waddr, ver_paddr, leave_addr, win_raddr;
  logic [PB-1:0]     count, len_m1;
  logic [HASH_W-1:0] win_hash, pat_hash, pow_fwd, pow_neg, red;
  logic              match_ok, ver_pend, lv_ok, found;

  // Reducer pipeline
  logic [7:0]         byte_r, leave_byte;
  logic [PROD_W-1:0]  x_r, x_next, quo_mul;
  logic [37:0]        leave_prod;
  logic [QPROD_W-1:0] qprod;
  logic [QUO_W-1:0]   quo_r;
  logic [REM_W-1:0]   rem_r;
  logic [31:0]        start_r;
  logic [CW:0]        lsum;
  logic [LW-1:0]      len_wide;
  logic               text_fix;

  // Clamp the length register to 1..MAX_PATTERN as it is written
  assign len_wide = LW'(cfg_data);
  assign len_next = (cfg_data == 7'd0)                 ? CW'(1)  :
                    (len_wide > LW'(MAX_PATTERN))      ? LEN_MAX :
                                                         CW'(cfg_data);

  // Leaving byte sits len steps behind the write pointer
  assign lsum       = (CW+1)'(wp) + (CW+1)'(MAX_PATTERN) - (CW+1)'(eff_len);
  assign leave_addr = (lsum >= (CW+1)'(MAX_PATTERN)) ? AW'(lsum - (CW+1)'(MAX_PATTERN))
                                                     : AW'(lsum);
  assign win_raddr  = cmd.ver_en ? ver_waddr : leave_addr;
  assign leave_byte = lv_ok ? win_rdata : 8'd0;

  // Reducer arithmetic
  assign leave_prod = 38'(leave_byte) * 38'(pow_neg);
  always_comb begin
    case (cmd.job)
      JOB_TEXT:  x_next = PROD_W'({win_hash, 8'd0}) + PROD_W'(byte_r) + PROD_W'(leave_prod);
      JOB_PHASH: x_next = PROD_W'({pat_hash, 8'd0}) + PROD_W'(byte_r);
      JOB_P256:  x_next = PROD_W'({pow_fwd, 8'd0});
      default:   x_next = '0;
    endcase
  end
  assign qprod   = QPROD_W'(x_r[PROD_W-1 -: XH_W]) * QPROD_W'(BARRETT_R);
  assign quo_mul = PROD_W'(quo_r) * PROD_W'(HASH_MOD);
  assign red     = (rem_r >= REM_W'(HASH_MOD)) ? HASH_W'(rem_r - REM_W'(HASH_MOD))
                                               : rem_r[HASH_W-1:0];

  assign len_m1   = PB'(eff_len - CW'(1));
  assign text_fix = cmd.fix_en && (cmd.job == JOB_TEXT);
  assign found    = cmd.fix_en ? 1'b0 : match_ok;

  assign status.idx_ok    = (32'(in_item.pattern_index) < 32'(MAX_PATTERN));
  assign status.idx_zero  = (in_item.pattern_index == 6'd0);
  assign status.hit       = (count >= len_m1) && (red == pat_hash);
  assign status.ver_done  = (ver_left == '0) && !ver_pend;
  assign status.slot_free = !out_valid || out_ready;

  // Memories
  always_ff @(posedge clk) begin
    if (text_fix) win_mem[wp] <= byte_r;
    win_rdata <= win_mem[win_raddr];
    if (cmd.pat_wr) pat_mem[AW'(in_item.pattern_index)] <= in_item.data_byte;
    pat_rdata <= pat_mem[ver_paddr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lv_ok <= (eff_len <= fill);
    if (cmd.accept) byte_r <= in_item.data_byte;
    if (cmd.mul_en) x_r    <= x_next;
    if (cmd.quo_en) quo_r  <= qprod[QPROD_W-1 -: QUO_W];
    if (cmd.sub_en) rem_r  <= REM_W'(x_r - quo_mul);
    if (text_fix) begin
      start_r   <= 32'(count - len_m1);
      ver_waddr <= wp;
      ver_paddr <= AW'(eff_len - CW'(1));
    end else if (cmd.ver_en && (ver_left != '0)) begin
      ver_waddr <= (ver_waddr == '0) ? ADDR_LAST : ver_waddr - AW'(1);
      ver_paddr <= ver_paddr - AW'(1);
    end
    if (cmd.out_load) begin
      out_item.match_found <= found;
      out_item.match_start <= found ? start_r : 32'd0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len   <= CW'(1);
      wp        <= '0;
      fill      <= '0;
      count     <= '0;
      win_hash  <= '0;
      pat_hash  <= '0;
      pow_fwd   <= BASE_POW1;
      pow_neg   <= NEG_BASE_POW1;
      match_ok  <= 1'b0;
      ver_pend  <= 1'b0;
      ver_left  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) eff_len <= len_next;

      if (cmd.pat_init) begin
        pat_hash <= HASH_W'(in_item.data_byte);
        pow_fwd  <= BASE_POW1;
        pow_neg  <= NEG_BASE_POW1;
      end

      if (cmd.restart) begin
        win_hash <= '0;
        count    <= '0;
        fill     <= '0;
      end

      if (cmd.fix_en) begin
        case (cmd.job)
          JOB_TEXT: begin
            win_hash <= red;
            wp       <= (wp == ADDR_LAST) ? '0 : wp + AW'(1);
            if (fill != LEN_MAX) fill <= fill + CW'(1);
            if (count != COUNT_MAX) count <= count + PB'(1);
            match_ok <= status.hit;
            ver_left <= eff_len;
            ver_pend <= 1'b0;
          end
          JOB_PHASH: pat_hash <= red;
          JOB_P256: begin
            pow_fwd <= red;
            pow_neg <= HASH_MOD - red;
          end
          default: ;
        endcase
      end

      // Verify: issue one read pair a cycle, compare the pair in the next cycle
      if (cmd.ver_en) begin
        if (ver_left != '0) begin
          ver_left <= ver_left - CW'(1);
          ver_pend <= 1'b1;
        end else begin
          ver_pend <= 1'b0;
        end
        if (ver_pend && (win_rdata != pat_rdata)) match_ok <= 1'b0;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/rolling_hash_substring_search.sv
// ----------------------------------------------------------------------------
// Rolling hash substring search - top level
// Streaming Rabin-Karp matcher: base 256, modulus 1000000007.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: write the pattern length (clamped to 1..MAX_PATTERN) while idle.
//   in channel: one beat per item. Opcode load writes pattern byte at pattern_index
//   (send in index order from zero), text streams one byte, restart begins a new text.
//   out channel: one beat per text byte; match_found set with the window start
//   offset in match_start when the last pattern-length bytes equal the pattern.
// Sequence (one item in flight, set by the shared multiply/reduce unit):
//   text byte, no hash hit: multiply, quotient, subtract and fix states, result
//   loaded at fix or, while out is full, in the result state. With a hash hit,
//   fix leads to verify and result; byte compare runs one pair a cycle through
//   the pattern and window memory ports. Load at nonzero index: two reductions;
//   load at index zero, restart and the spare opcode: taken in idle alone.
// Reset: hashes and counters cleared, leading power 256, length 1; pattern store
//   holds nothing valid until loaded.
// Stall: the output register holds one result; the block keeps taking items
//   until a second result is ready, then holds until the first beat leaves.
// ----------------------------------------------------------------------------
module rolling_hash_substring_search #(
  parameter int unsigned MAX_PATTERN   = rhss_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = rhss_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rhss_pkg::rhss_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rhss_pkg::rhss_out_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import rhss_pkg::*;

  rhss_cmd_t    cmd;
  rhss_status_t status;

  // Length writes go straight into the length register, so the config port never stalls
  assign cfg_ready = 1'b1;

  // Sequence each item through accept, reduce, verify and hand-off
  rhss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (in_item.opcode),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the stores, hashes and output register
  rhss_dpath #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/core/rhss_checker.sv
// ----------------------------------------------------------------------------
// Rolling hash substring search - port checker
// Watches the top-level ports for timing and result consistency.
// ----------------------------------------------------------------------------
module rhss_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input rhss_pkg::rhss_in_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input rhss_pkg::rhss_out_t out_item
);
  import rhss_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // A miss reports a zero start
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.match_found |-> out_item.match_start == 32'd0)
    else $error("miss with nonzero start");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // A text byte keeps the input closed through the reduction
  a_text_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.opcode == OP_TEXT |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input reopened during reduction");

endmodule

bind rolling_hash_substring_search rhss_checker u_rhss_checker (.*);
